[rtl/efra_pkg.sv]
// Shared types, constants and helpers for the earliest-free resource allocator.
package efra_pkg;

	localparam int unsigned MAX_RESOURCES = 16;
	localparam int unsigned IDX_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned TAG_W = 16;
	localparam int unsigned ID_W = 5;
	localparam int unsigned CFG_W = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

	typedef struct packed {
		logic [TIME_W-1:0] interval_end;
		logic [TAG_W-1:0]  item_tag;
		logic              batch_start;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0]  resource_id;
		logic [TAG_W-1:0] result_tag;
	} result_t;

	// Update of one table entry after a selection
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [TIME_W-1:0] free_time;
	} tbl_wr_t;

	// Sequencer status seen by the top level
	typedef struct packed {
		logic             idle;
		logic             done;
		logic [IDX_W-1:0] best;
	} scan_stat_t;

	typedef enum logic [2:0] {
		SC_IDLE = 3'b001,
		SC_SCAN = 3'b010,
		SC_DONE = 3'b100
	} scan_state_t;

	// Clamp the resource count to 1..MAX_RESOURCES and return the last index
	function automatic logic [IDX_W-1:0] last_index(input logic [CFG_W-1:0] k);
		int unsigned kk;
		kk = int'(k);
		if (kk < 1) kk = 1;
		if (kk > MAX_RESOURCES) kk = MAX_RESOURCES;
		return IDX_W'(kk - 1);
	endfunction

endpackage

[rtl/efra_table.sv]
// Per-resource free times and used bits, one read and one write port.
module efra_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  efra_pkg::tbl_wr_t             wr,
	input  logic [efra_pkg::IDX_W-1:0]    rd_idx,
	output logic                          rd_used,
	output logic [efra_pkg::TIME_W-1:0]   rd_time
);

	logic [efra_pkg::MAX_RESOURCES-1:0] used_q;
	logic [efra_pkg::TIME_W-1:0]        time_q [efra_pkg::MAX_RESOURCES];

	// Clear all used bits on batch start, set one on update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (clear) begin
			used_q <= '0;
		end else if (wr.en) begin
			used_q[wr.idx] <= 1'b1;
		end
	end

	// Store the new free time; unused entries never take part by their time
	always_ff @(posedge clk) begin
		if (wr.en) begin
			time_q[wr.idx] <= wr.free_time;
		end
	end

	assign rd_used = used_q[rd_idx];
	assign rd_time = time_q[rd_idx];

endmodule

[rtl/efra_scan.sv]
// Sequencer that walks the active resources through one shared comparator.
module efra_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [efra_pkg::IDX_W-1:0]    last_idx,
	input  logic                          release_done,
	input  logic                          rd_used,
	input  logic [efra_pkg::TIME_W-1:0]   rd_time,
	output logic [efra_pkg::IDX_W-1:0]    rd_idx,
	output efra_pkg::scan_stat_t          stat
);

	efra_pkg::scan_state_t       state_q;
	logic [efra_pkg::IDX_W-1:0]  idx_q;
	logic [efra_pkg::IDX_W-1:0]  last_q;
	logic [efra_pkg::IDX_W-1:0]  best_q;
	logic                        best_used_q;
	logic [efra_pkg::TIME_W-1:0] best_time_q;
	logic                        better;

	// Shared compare: an unused entry beats a used one, else the earlier free time
	always_comb begin
		if (rd_used != best_used_q) begin
			better = !rd_used;
		end else begin
			better = rd_used && (rd_time < best_time_q);
		end
	end

	// Step through entries 0..last, one per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efra_pkg::SC_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				efra_pkg::SC_IDLE: begin
					if (start) begin
						state_q <= efra_pkg::SC_SCAN;
						idx_q   <= '0;
					end
				end
				efra_pkg::SC_SCAN: begin
					if (idx_q == last_q) begin
						state_q <= efra_pkg::SC_DONE;
					end else begin
						idx_q <= idx_q + efra_pkg::IDX_W'(1);
					end
				end
				efra_pkg::SC_DONE: begin
					if (release_done) begin
						state_q <= efra_pkg::SC_IDLE;
					end
				end
				default: begin
					state_q <= efra_pkg::SC_IDLE;
				end
			endcase
		end
	end

	// Hold the scan bound and the best entry so far
	always_ff @(posedge clk) begin
		if (start && (state_q == efra_pkg::SC_IDLE)) begin
			last_q <= last_idx;
		end
		if ((state_q == efra_pkg::SC_SCAN) && ((idx_q == '0) || better)) begin
			best_q      <= idx_q;
			best_used_q <= rd_used;
			best_time_q <= rd_time;
		end
	end

	assign rd_idx    = idx_q;
	assign stat.idle = (state_q == efra_pkg::SC_IDLE);
	assign stat.done = (state_q == efra_pkg::SC_DONE);
	assign stat.best = best_q;

endmodule

[rtl/earliest_free_resource_allocator.sv]
// Top level of the earliest-free resource allocator.
// Each accepted interval goes to the active resource that becomes free first
// (never-used resources first, ties to the lowest id); the result carries the
// resource id, numbered from 1, and the item's tag. With k active resources, one
// comparator examines the k table entries one after another in the scan state;
// the done state then writes the table and loads the result register, and the
// block returns to idle, where the next item is accepted. The write is held off
// while an earlier result still waits under stall in the result register.
// Batch start clears all resources at the accepting edge.
// The result register lets a finished result wait while the next item enters.
module earliest_free_resource_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  efra_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output efra_pkg::result_t               result,
	input  logic                            cfg_we,
	input  logic [efra_pkg::CFG_W-1:0]      cfg_wdata
);

	logic [efra_pkg::CFG_W-1:0]  resources_in_use_q;
	efra_pkg::item_t             item_q;
	efra_pkg::result_t           result_q;
	logic                        result_valid_q;
	logic                        item_xfer;
	logic                        finish;
	efra_pkg::tbl_wr_t           wr;
	efra_pkg::scan_stat_t        stat;
	logic [efra_pkg::IDX_W-1:0]  rd_idx;
	logic                        rd_used;
	logic [efra_pkg::TIME_W-1:0] rd_time;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resources_in_use_q <= efra_pkg::CFG_RESET;
		end else if (cfg_we) begin
			resources_in_use_q <= cfg_wdata;
		end
	end

	assign item_stall = !stat.idle;
	assign item_xfer  = item_valid && !item_stall;
	assign finish     = stat.done && (!result_valid_q || !result_stall);

	// Capture the item on transfer
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			item_q <= item;
		end
	end

	assign wr.en        = finish;
	assign wr.idx       = stat.best;
	assign wr.free_time = item_q.interval_end;

	efra_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (item_xfer && item.batch_start),
		.wr      (wr),
		.rd_idx  (rd_idx),
		.rd_used (rd_used),
		.rd_time (rd_time)
	);

	efra_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (item_xfer),
		.last_idx     (efra_pkg::last_index(resources_in_use_q)),
		.release_done (finish),
		.rd_used      (rd_used),
		.rd_time      (rd_time),
		.rd_idx       (rd_idx),
		.stat         (stat)
	);

	// Result register: load on finish, drop on output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (finish) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result_q.resource_id <= efra_pkg::ID_W'(
				{{(efra_pkg::ID_W + 1){1'b0}}, stat.best} + 1'b1);
			result_q.result_tag  <= item_q.item_tag;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	// An accepted item always starts a scan
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer |=> !stat.idle)
		else $error("scan did not start after item transfer");

	// Table updates only happen at the end of a scan
	a_wr_done: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (stat.done && !stat.idle))
		else $error("table write outside scan completion");

	// A new result only appears after a completed scan
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(stat.done))
		else $error("result without completed scan");

	// The chosen resource lies within the scanned range
	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (wr.idx <= u_scan.last_q))
		else $error("selected resource beyond active count");
`endif

endmodule
